@@ hdl/iee_pkg.sv @@
// Package for the infix expression evaluator: payload structs, operator and
// status codes, stack depths. No dependencies.
package iee_pkg;

  localparam int unsigned OperatorDepth = 64;
  localparam int unsigned ValueDepth    = 64;
  localparam int unsigned OpAw          = $clog2(OperatorDepth);
  localparam int unsigned ValAw         = $clog2(ValueDepth);
  localparam int unsigned OpCw          = $clog2(OperatorDepth + 1);
  localparam int unsigned ValCw         = $clog2(ValueDepth + 1);

  typedef enum logic [2:0] {
    OP_LPAREN = 3'd0,
    OP_ADD    = 3'd1,
    OP_SUB    = 3'd2,
    OP_MUL    = 3'd3,
    OP_DIV    = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_DIVZERO   = 3'd1,
    ST_UNDERFLOW = 3'd2,
    ST_OVERFLOW  = 3'd3,
    ST_PAREN     = 3'd4
  } status_e;

  localparam logic [7:0] ChZero   = 8'd48;
  localparam logic [7:0] ChNine   = 8'd57;
  localparam logic [7:0] ChLparen = 8'h28;
  localparam logic [7:0] ChRparen = 8'h29;
  localparam logic [7:0] ChMul    = 8'h2a;
  localparam logic [7:0] ChAdd    = 8'h2b;
  localparam logic [7:0] ChSub    = 8'h2d;
  localparam logic [7:0] ChDiv    = 8'h2f;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } in_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [2:0]         status;
  } out_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

endpackage

@@ hdl/iee_div.sv @@
// Iterative signed divider for the evaluator, one quotient bit per cycle.
// Depends on iee_pkg. Truncates toward zero; the caller handles a zero divisor.
module iee_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  iee_pkg::div_req_t req_i,
  output logic              busy_o,
  output logic [31:0]       quot_o
);

  logic [31:0] rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        neg_q, neg_d, busy_q, busy_d;
  logic [32:0] trial;
  logic [31:0] shifted;
  logic [31:0] a_abs, b_abs;

  assign a_abs   = req_i.dividend[31] ? (~req_i.dividend + 32'd1) : req_i.dividend;
  assign b_abs   = req_i.divisor[31] ? (~req_i.divisor + 32'd1) : req_i.divisor;
  assign shifted = {rem_q[30:0], quo_q[31]};
  assign trial   = {1'b0, shifted} - {1'b0, den_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    busy_d = busy_q;
    if (req_i.start) begin
      rem_d  = '0;
      quo_d  = a_abs;
      den_d  = b_abs;
      cnt_d  = 6'd32;
      neg_d  = req_i.dividend[31] ^ req_i.divisor[31];
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[32]) begin
        rem_d = trial[31:0];
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign busy_o = busy_q;
  assign quot_o = neg_q ? (~quo_q + 32'd1) : quo_q;

endmodule

@@ hdl/infix_expression_evaluator.sv @@
// Top level of the infix expression evaluator: sequencer, operator and value
// stack memories, multiplier register. Depends on iee_pkg and iee_div.
// One character is taken at a time. A digit or an opening parenthesis passes
// through decode and push; an operator also reads the operator stack top
// first. Each operator popped reads the operator stack and both operands,
// executes and writes back, waiting in S_DIVW for a multiplication or for
// the bit-serial divider. A final character adds the flush of all remaining
// operators, then reads the top value, loads the output register and raises
// valid; the output register is held until the result transfer. Further
// characters are taken while a result waits, and the next final character
// holds at the end of its flush until that transfer.
module infix_expression_evaluator (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  iee_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output iee_pkg::out_t out_data_o
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_DEC   = 10'b0000000010,
    S_OPRD  = 10'b0000000100,
    S_OPCHK = 10'b0000001000,
    S_VRD1  = 10'b0000010000,
    S_VRD2  = 10'b0000100000,
    S_EXEC  = 10'b0001000000,
    S_DIVW  = 10'b0010000000,
    S_PUSH  = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_e;

  typedef enum logic [1:0] {
    K_OPER = 2'd0,
    K_RPAR = 2'd1,
    K_FLSH = 2'd2
  } kind_e;

  state_e state_q, state_d;
  kind_e  kind_q, kind_d;

  logic [2:0]  op_mem [iee_pkg::OperatorDepth];
  logic [31:0] val_mem [iee_pkg::ValueDepth];
  logic [2:0]  op_rd_q;
  logic [31:0] val_rd_q;

  logic                   op_we, val_we;
  logic [iee_pkg::OpAw-1:0]  op_wa, op_ra;
  logic [iee_pkg::ValAw-1:0] val_wa, val_ra;
  logic [2:0]             op_wd;
  logic [31:0]            val_wd;

  logic [iee_pkg::OpCw-1:0]  opc_q, opc_d;
  logic [iee_pkg::ValCw-1:0] vc_q, vc_d;
  logic [2:0]  err_q, err_d;
  logic [7:0]  ch_q, ch_d;
  logic        last_q, last_d;
  logic [2:0]  inop_q, inop_d;
  logic [2:0]  curop_q, curop_d;
  logic [31:0] rhs_q, rhs_d, lhs_q, lhs_d;
  iee_pkg::out_t res_q, res_d;
  logic        ov_q, ov_d;

  iee_pkg::div_req_t div_req;
  logic        div_busy;
  logic [31:0] div_quot;
  logic [31:0] prod;
  logic        pops;

  iee_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .busy_o (div_busy),
    .quot_o (div_quot)
  );

  always_ff @(posedge clk_i) begin
    if (op_we) op_mem[op_wa] <= op_wd;
    op_rd_q <= op_mem[op_ra];
  end

  always_ff @(posedge clk_i) begin
    if (val_we) val_mem[val_wa] <= val_wd;
    val_rd_q <= val_mem[val_ra];
  end

  assign prod = lhs_q * rhs_q;

  always_comb begin
    if (op_rd_q == iee_pkg::OP_LPAREN) pops = 1'b0;
    else if (inop_q == iee_pkg::OP_MUL || inop_q == iee_pkg::OP_DIV)
      pops = (op_rd_q == iee_pkg::OP_MUL || op_rd_q == iee_pkg::OP_DIV);
    else pops = 1'b1;
  end

  function automatic logic [2:0] flag_f(logic [2:0] cur, iee_pkg::status_e code);
    return (cur == iee_pkg::ST_OK) ? code : cur;
  endfunction

  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    opc_d   = opc_q;
    vc_d    = vc_q;
    err_d   = err_q;
    ch_d    = ch_q;
    last_d  = last_q;
    inop_d  = inop_q;
    curop_d = curop_q;
    rhs_d   = rhs_q;
    lhs_d   = lhs_q;
    res_d   = res_q;
    ov_d    = ov_q;
    op_we   = 1'b0;
    op_wa   = opc_q[iee_pkg::OpAw-1:0];
    op_wd   = inop_q;
    op_ra   = opc_q[iee_pkg::OpAw-1:0] - 1'b1;
    val_we  = 1'b0;
    val_wa  = vc_q[iee_pkg::ValAw-1:0];
    val_wd  = '0;
    val_ra  = vc_q[iee_pkg::ValAw-1:0] - 1'b1;
    div_req = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ch_d    = in_data_i.ch;
          last_d  = in_data_i.last;
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        state_d = S_PUSH;
        kind_d  = K_OPER;
        priority if (ch_q >= iee_pkg::ChZero && ch_q <= iee_pkg::ChNine) begin
          if (vc_q >= iee_pkg::ValCw'(iee_pkg::ValueDepth)) begin
            err_d = flag_f(err_q, iee_pkg::ST_OVERFLOW);
          end else begin
            val_we = 1'b1;
            val_wd = {24'd0, ch_q - iee_pkg::ChZero};
            vc_d   = vc_q + 1'b1;
          end
        end else if (ch_q == iee_pkg::ChLparen) begin
          if (opc_q >= iee_pkg::OpCw'(iee_pkg::OperatorDepth)) begin
            err_d = flag_f(err_q, iee_pkg::ST_OVERFLOW);
          end else begin
            op_we = 1'b1;
            op_wd = iee_pkg::OP_LPAREN;
            opc_d = opc_q + 1'b1;
          end
        end else if (ch_q == iee_pkg::ChRparen) begin
          kind_d  = K_RPAR;
          state_d = S_OPRD;
        end else if (ch_q == iee_pkg::ChAdd || ch_q == iee_pkg::ChSub ||
                     ch_q == iee_pkg::ChMul || ch_q == iee_pkg::ChDiv) begin
          unique case (ch_q)
            iee_pkg::ChAdd: inop_d = iee_pkg::OP_ADD;
            iee_pkg::ChSub: inop_d = iee_pkg::OP_SUB;
            iee_pkg::ChMul: inop_d = iee_pkg::OP_MUL;
            default:        inop_d = iee_pkg::OP_DIV;
          endcase
          state_d = S_OPRD;
        end
      end
      S_OPRD: begin
        if (opc_q == '0) begin
          if (kind_q == K_RPAR) begin
            err_d   = flag_f(err_q, iee_pkg::ST_PAREN);
            state_d = S_PUSH;
          end else if (kind_q == K_FLSH) begin
            if (vc_q == '0) err_d = flag_f(err_q, iee_pkg::ST_UNDERFLOW);
            curop_d = iee_pkg::OP_LPAREN;
            state_d = S_VRD1;
          end else begin
            state_d = S_PUSH;
          end
        end else begin
          state_d = S_OPCHK;
        end
      end
      S_OPCHK: begin
        curop_d = op_rd_q;
        if (kind_q == K_RPAR && op_rd_q == iee_pkg::OP_LPAREN) begin
          opc_d   = opc_q - 1'b1;
          kind_d  = K_OPER;
          state_d = S_PUSH;
        end else if (kind_q == K_FLSH && op_rd_q == iee_pkg::OP_LPAREN) begin
          opc_d   = opc_q - 1'b1;
          err_d   = flag_f(err_q, iee_pkg::ST_PAREN);
          state_d = S_OPRD;
        end else if (kind_q == K_OPER && !pops) begin
          state_d = S_PUSH;
        end else begin
          opc_d = opc_q - 1'b1;
          if (vc_q < iee_pkg::ValCw'(2)) begin
            err_d   = flag_f(err_q, iee_pkg::ST_UNDERFLOW);
            state_d = S_OPRD;
          end else begin
            state_d = S_VRD1;
          end
        end
      end
      S_VRD1: begin
        val_ra  = vc_q[iee_pkg::ValAw-1:0] - 1'b1;
        state_d = S_VRD2;
      end
      S_VRD2: begin
        rhs_d = val_rd_q;
        if (kind_q == K_FLSH && opc_q == '0 && state_q == S_VRD2 &&
            curop_q == iee_pkg::OP_LPAREN) begin
          state_d = S_EXEC;
        end else begin
          val_ra  = vc_q[iee_pkg::ValAw-1:0] - 2'd2;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (kind_q == K_FLSH && curop_q == iee_pkg::OP_LPAREN) begin
          if (!ov_q || out_ready_i) begin
            res_d.value  = (err_q == iee_pkg::ST_OK) ? rhs_q : 32'd0;
            res_d.status = err_q;
            if (vc_q == '0) res_d.value = 32'd0;
            state_d = S_OUT;
          end
        end else begin
          lhs_d = val_rd_q;
          unique case (curop_q)
            iee_pkg::OP_ADD: begin
              val_we = 1'b1; val_wd = val_rd_q + rhs_q;
            end
            iee_pkg::OP_SUB: begin
              val_we = 1'b1; val_wd = val_rd_q - rhs_q;
            end
            iee_pkg::OP_MUL: begin
              state_d = S_DIVW;
            end
            default: begin
              if (rhs_q == '0) begin
                err_d  = flag_f(err_q, iee_pkg::ST_DIVZERO);
                val_we = 1'b1;
              end else begin
                div_req.start    = 1'b1;
                div_req.dividend = val_rd_q;
                div_req.divisor  = rhs_q;
                state_d = S_DIVW;
              end
            end
          endcase
          val_wa = vc_q[iee_pkg::ValAw-1:0] - 2'd2;
          if (val_we) begin
            vc_d    = vc_q - 1'b1;
            state_d = S_OPRD;
          end
        end
      end
      S_DIVW: begin
        val_wa = vc_q[iee_pkg::ValAw-1:0] - 2'd2;
        if (curop_q == iee_pkg::OP_MUL) begin
          val_we = 1'b1; val_wd = prod;
        end else if (!div_busy) begin
          val_we = 1'b1; val_wd = div_quot;
        end
        if (val_we) begin
          vc_d    = vc_q - 1'b1;
          state_d = S_OPRD;
        end
      end
      S_PUSH: begin
        if (kind_q == K_OPER && (ch_q == iee_pkg::ChAdd || ch_q == iee_pkg::ChSub ||
            ch_q == iee_pkg::ChMul || ch_q == iee_pkg::ChDiv)) begin
          if (opc_q >= iee_pkg::OpCw'(iee_pkg::OperatorDepth)) begin
            err_d = flag_f(err_q, iee_pkg::ST_OVERFLOW);
          end else begin
            op_we = 1'b1;
            opc_d = opc_q + 1'b1;
          end
        end
        ch_d = '0;
        if (last_q) begin
          kind_d  = K_FLSH;
          curop_d = iee_pkg::OP_LPAREN;
          state_d = S_OPRD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_OUT: begin
        if (!ov_q) begin
          ov_d    = 1'b1;
          opc_d   = '0;
          vc_d    = '0;
          err_d   = iee_pkg::ST_OK;
          last_d  = 1'b0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (ov_q && out_ready_i) ov_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      kind_q  <= K_OPER;
      opc_q   <= '0;
      vc_q    <= '0;
      err_q   <= iee_pkg::ST_OK;
      last_q  <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
      opc_q   <= opc_d;
      vc_q    <= vc_d;
      err_q   <= err_d;
      last_q  <= last_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q    <= ch_d;
    inop_q  <= inop_d;
    curop_q <= curop_d;
    rhs_q   <= rhs_d;
    lhs_q   <= lhs_d;
    res_q   <= res_d;
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = res_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vc_q <= iee_pkg::ValCw'(iee_pkg::ValueDepth) &&
    opc_q <= iee_pkg::OpCw'(iee_pkg::OperatorDepth))
    else $error("stack count beyond depth");
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == S_IDLE)
    else $error("input taken outside idle");
  a_out_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && out_valid_o && $rose(ov_q)) |-> vc_q == '0 && opc_q == '0)
    else $error("stacks not cleared at result");
  a_err_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ov_q) |-> (res_q.status == iee_pkg::ST_OK || res_q.value == 32'd0))
    else $error("non-zero value with error status");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !out_ready_i) |=> (ov_q && $stable(res_q)))
    else $error("result changed while waiting");

endmodule

@@ tb/infix_expression_evaluator_tb.sv @@
// Testbench for infix_expression_evaluator: sends expressions one character per
// transfer and checks each result against an in-bench shunting-yard evaluator.
// Depends on iee_pkg and the evaluator RTL.
module infix_expression_evaluator_tb;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic out_ready_i = 1'b0;
  iee_pkg::in_t  in_data_i = '0;
  logic in_ready_o;
  logic out_valid_o;
  iee_pkg::out_t out_data_o;

  infix_expression_evaluator u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o
  );

  always #2 clk_i = ~clk_i;

  iee_pkg::op_e     op_stack [iee_pkg::OperatorDepth];
  int unsigned      op_cnt;
  logic [31:0]      val_stack [iee_pkg::ValueDepth];
  int unsigned      val_cnt;
  iee_pkg::status_e err_code;
  iee_pkg::out_t    expected_q [$];

  int unsigned errors;
  int unsigned chars_sent;
  int unsigned results_seen;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          hold_off;
  int unsigned idle_cycles;

  function automatic void flag_error(iee_pkg::status_e code);
    if (err_code == iee_pkg::ST_OK) err_code = code;
  endfunction

  function automatic void apply_op(iee_pkg::op_e op);
    logic [31:0] lhs, rhs, res;
    if (val_cnt < 2) begin
      flag_error(iee_pkg::ST_UNDERFLOW);
      return;
    end
    rhs = val_stack[val_cnt-1];
    lhs = val_stack[val_cnt-2];
    val_cnt -= 2;
    case (op)
      iee_pkg::OP_ADD: res = lhs + rhs;
      iee_pkg::OP_SUB: res = lhs - rhs;
      iee_pkg::OP_MUL: res = lhs * rhs;
      default: begin
        if (rhs == 0) begin
          flag_error(iee_pkg::ST_DIVZERO);
          res = '0;
        end else if (lhs == 32'h8000_0000 && rhs == 32'hffff_ffff) begin
          res = lhs;
        end else begin
          res = $signed(lhs) / $signed(rhs);
        end
      end
    endcase
    val_stack[val_cnt] = res;
    val_cnt++;
  endfunction

  function automatic void push_op(iee_pkg::op_e op);
    if (op_cnt >= iee_pkg::OperatorDepth) begin
      flag_error(iee_pkg::ST_OVERFLOW);
      return;
    end
    op_stack[op_cnt] = op;
    op_cnt++;
  endfunction

  function automatic bit pops_first(iee_pkg::op_e incoming, iee_pkg::op_e top);
    if (top == iee_pkg::OP_LPAREN) return 1'b0;
    if (incoming == iee_pkg::OP_MUL || incoming == iee_pkg::OP_DIV)
      return top == iee_pkg::OP_MUL || top == iee_pkg::OP_DIV;
    return 1'b1;
  endfunction

  function automatic void clear_evaluator();
    op_cnt = 0;
    val_cnt = 0;
    err_code = iee_pkg::ST_OK;
  endfunction

  function automatic void evaluate_char(iee_pkg::in_t item);
    iee_pkg::op_e  op;
    iee_pkg::out_t res;
    bit            is_op;
    is_op = 1'b1;
    if (item.ch >= iee_pkg::ChZero && item.ch <= iee_pkg::ChNine) begin
      is_op = 1'b0;
      if (val_cnt >= iee_pkg::ValueDepth) flag_error(iee_pkg::ST_OVERFLOW);
      else begin
        val_stack[val_cnt] = 32'(item.ch - iee_pkg::ChZero);
        val_cnt++;
      end
    end else if (item.ch == iee_pkg::ChLparen) begin
      is_op = 1'b0;
      push_op(iee_pkg::OP_LPAREN);
    end else if (item.ch == iee_pkg::ChRparen) begin
      is_op = 1'b0;
      while (op_cnt > 0 && op_stack[op_cnt-1] != iee_pkg::OP_LPAREN) begin
        op_cnt--;
        apply_op(op_stack[op_cnt]);
      end
      if (op_cnt == 0) flag_error(iee_pkg::ST_PAREN);
      else op_cnt--;
    end else if (item.ch == iee_pkg::ChAdd) op = iee_pkg::OP_ADD;
    else if (item.ch == iee_pkg::ChSub) op = iee_pkg::OP_SUB;
    else if (item.ch == iee_pkg::ChMul) op = iee_pkg::OP_MUL;
    else if (item.ch == iee_pkg::ChDiv) op = iee_pkg::OP_DIV;
    else is_op = 1'b0;
    if (is_op) begin
      while (op_cnt > 0 && pops_first(op, op_stack[op_cnt-1])) begin
        op_cnt--;
        apply_op(op_stack[op_cnt]);
      end
      push_op(op);
    end
    if (!item.last) return;
    while (op_cnt > 0) begin
      op_cnt--;
      if (op_stack[op_cnt] == iee_pkg::OP_LPAREN) flag_error(iee_pkg::ST_PAREN);
      else apply_op(op_stack[op_cnt]);
    end
    res.value = '0;
    if (val_cnt == 0) flag_error(iee_pkg::ST_UNDERFLOW);
    else res.value = val_stack[val_cnt-1];
    if (err_code != iee_pkg::ST_OK) res.value = '0;
    res.status = err_code;
    expected_q.push_back(res);
    clear_evaluator();
  endfunction

  task automatic send_char(input logic [7:0] ch, input bit last);
    while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) @(posedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i <= '{ch: ch, last: last};
    do @(posedge clk_i); while (!in_ready_o);
    evaluate_char('{ch: ch, last: last});
    chars_sent++;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  task automatic drain();
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        $display("%0t unexpected result value=%0d status=%0d", $time,
                 out_data_o.value, out_data_o.status);
        errors++;
      end else begin
        if (out_data_o.value !== expected_q[0].value ||
            out_data_o.status !== expected_q[0].status) begin
          $display("%0t expected value=%0d status=%0d actual value=%0d status=%0d", $time,
                   expected_q[0].value, expected_q[0].status, out_data_o.value,
                   out_data_o.status);
          errors++;
        end
        void'(expected_q.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_off) out_ready_i <= 1'b0;
    else out_ready_i <= recv_stall_pct == 0 || $urandom_range(99, 0) >= recv_stall_pct;
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 200000) begin
      $display("infix_expression_evaluator: mismatch");
      $finish;
    end
  end

  function automatic logic [7:0] random_token(bit noisy);
    int unsigned r;
    r = $urandom_range(99, 0);
    if (noisy && r < 10) return 8'($urandom);
    if (r < 50) return iee_pkg::ChZero + 8'($urandom_range(9, 0));
    case ($urandom_range(5, 0))
      0: return iee_pkg::ChAdd;
      1: return iee_pkg::ChSub;
      2: return iee_pkg::ChMul;
      3: return iee_pkg::ChDiv;
      4: return iee_pkg::ChLparen;
      default: return iee_pkg::ChRparen;
    endcase
  endfunction

  // Well-formed expression with random digits, operators and nesting.
  function automatic string random_expr(int depth);
    string s;
    int n;
    n = $urandom_range(3, 1);
    for (int i = 0; i < n; i++) begin
      if (i > 0) begin
        case ($urandom_range(3, 0))
          0: s = {s, "+"};
          1: s = {s, "-"};
          2: s = {s, "*"};
          default: s = {s, "/"};
        endcase
      end
      if (depth > 0 && $urandom_range(3, 0) == 0) s = {s, "(", random_expr(depth - 1), ")"};
      else s = {s, string'(iee_pkg::ChZero + 8'($urandom_range(9, 0)))};
    end
    return s;
  endfunction

  task automatic test_basic_operations();
    send_text("7");
    send_text("3+4*2");
    send_text("9-2-3");
    send_text("8/3/2");
    send_text("(1+2)*3");
    send_text("0-7/2");
    send_text("(9)");
    send_char(8'hff, 1'b0);
    send_char(8'h00, 1'b0);
    send_text("5");
  endtask

  task automatic test_error_cases();
    send_text("5/0");
    send_text("3+");
    send_text("+");
    send_text("1)");
    send_text("(1");
    send_char(8'h20, 1'b1);
    send_text("1 2 3");
    send_text("0-9*9*9*9*9*9*9*9*9*9*9/(0-1)");
  endtask

  task automatic test_stack_limits();
    for (int i = 0; i < iee_pkg::ValueDepth + 2; i++) send_char(iee_pkg::ChNine, 1'b0);
    send_char(iee_pkg::ChNine, 1'b1);
    for (int i = 0; i < iee_pkg::OperatorDepth + 2; i++) send_char(iee_pkg::ChLparen, 1'b0);
    send_char(iee_pkg::ChRparen, 1'b1);
    // Build minus two to the 24th, then divide it by minus one.
    send_text("(0-8)*4*4*4*4*4*4*4*4*4*4*2/(0-1)");
    send_text("9*9*9*9*9*9*9*9*9*9*9*9");
  endtask

  task automatic run_random(int unsigned count);
    int unsigned stop;
    string s;
    stop = chars_sent + count;
    while (chars_sent < stop) begin
      if ($urandom_range(99, 0) < 80) begin
        s = random_expr(3);
        send_text(s);
      end else begin
        for (int n = $urandom_range(12, 0); n > 0; n--) send_char(random_token(1'b1), 1'b0);
        send_char(random_token(1'b1), 1'b1);
      end
    end
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk_i);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 6; i++) send_text("1+2");
    join
    drain();
    repeat (20) @(posedge clk_i);
    send_text("(4-6)*3");
  endtask

  task automatic test_random_phases();
    send_idle_pct = 0;  recv_stall_pct = 0;  run_random(265);
    send_idle_pct = 47; recv_stall_pct = 0;  run_random(265);
    send_idle_pct = 0;  recv_stall_pct = 47; run_random(265);
    send_idle_pct = 9;  recv_stall_pct = 9;  run_random(265);
  endtask

  initial begin
    errors = 0;
    chars_sent = 0;
    results_seen = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off = 1'b0;
    idle_cycles = 0;
    clear_evaluator();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_basic_operations();
    test_error_cases();
    test_stack_limits();
    test_backpressure();
    test_random_phases();
    drain();
    repeat (200) @(posedge clk_i);
    $display("Sent %0d characters, checked %0d expression results,", chars_sent, results_seen);
    $display("covering all operators, every status code and both stack limits.");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("infix_expression_evaluator: match");
    end else begin
      $display("infix_expression_evaluator: mismatch");
    end
    $finish;
  end

endmodule
